FILE: rtl/sc1a_pkg.sv
// Package for the scan-code set 1 to ASCII decoder.
// Holds the special scan codes, the keymap and the shift mapping.
// Has no dependencies.
package sc1a_pkg;

  localparam logic [7:0] CODE_PREFIX      = 8'hE0;
  localparam logic [7:0] CODE_LSHIFT_MAKE = 8'h2A;
  localparam logic [7:0] CODE_RSHIFT_MAKE = 8'h36;
  localparam logic [7:0] CODE_LSHIFT_BRK  = 8'hAA;
  localparam logic [7:0] CODE_RSHIFT_BRK  = 8'hB6;
  localparam int unsigned BREAK_BIT       = 7;

  typedef logic [7:0] scan_code_t;
  typedef logic [6:0] ascii_t;

  function automatic ascii_t keymap(input logic [6:0] code);
    ascii_t c;
    case (code)
      7'h02: c = 7'h31;
      7'h03: c = 7'h32;
      7'h04: c = 7'h33;
      7'h05: c = 7'h34;
      7'h06: c = 7'h35;
      7'h07: c = 7'h36;
      7'h08: c = 7'h37;
      7'h09: c = 7'h38;
      7'h0A: c = 7'h39;
      7'h0B: c = 7'h30;
      7'h0C: c = 7'h2D;
      7'h0D: c = 7'h3D;
      7'h0E: c = 7'h08;
      7'h10: c = 7'h71;
      7'h11: c = 7'h77;
      7'h12: c = 7'h65;
      7'h13: c = 7'h72;
      7'h14: c = 7'h74;
      7'h15: c = 7'h79;
      7'h16: c = 7'h75;
      7'h17: c = 7'h69;
      7'h18: c = 7'h6F;
      7'h19: c = 7'h70;
      7'h1A: c = 7'h5B;
      7'h1B: c = 7'h5D;
      7'h1C: c = 7'h0A;
      7'h1E: c = 7'h61;
      7'h1F: c = 7'h73;
      7'h20: c = 7'h64;
      7'h21: c = 7'h66;
      7'h22: c = 7'h67;
      7'h23: c = 7'h68;
      7'h24: c = 7'h6A;
      7'h25: c = 7'h6B;
      7'h26: c = 7'h6C;
      7'h27: c = 7'h3B;
      7'h28: c = 7'h27;
      7'h29: c = 7'h60;
      7'h2B: c = 7'h5C;
      7'h2C: c = 7'h7A;
      7'h2D: c = 7'h78;
      7'h2E: c = 7'h63;
      7'h2F: c = 7'h76;
      7'h30: c = 7'h62;
      7'h31: c = 7'h6E;
      7'h32: c = 7'h6D;
      7'h33: c = 7'h2C;
      7'h34: c = 7'h2E;
      7'h35: c = 7'h2F;
      7'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic ascii_t shifted(input ascii_t c);
    ascii_t s;
    case (c)
      7'h31: s = 7'h21;
      7'h32: s = 7'h40;
      7'h33: s = 7'h23;
      7'h34: s = 7'h24;
      7'h35: s = 7'h25;
      7'h36: s = 7'h5E;
      7'h37: s = 7'h26;
      7'h38: s = 7'h2A;
      7'h39: s = 7'h28;
      7'h30: s = 7'h29;
      7'h2D: s = 7'h5F;
      7'h3D: s = 7'h2B;
      7'h5B: s = 7'h7B;
      7'h5D: s = 7'h7D;
      7'h3B: s = 7'h3A;
      7'h27: s = 7'h22;
      7'h60: s = 7'h7E;
      7'h5C: s = 7'h7C;
      7'h2C: s = 7'h3C;
      7'h2E: s = 7'h3E;
      7'h2F: s = 7'h3F;
      default: begin
        if (c >= 7'h61 && c <= 7'h7A) begin
          s = c - 7'h20;
        end else begin
          s = c;
        end
      end
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/scancode_set1_to_ascii.sv
// Top level of the scan-code set 1 to ASCII decoder.
// Uses sc1a_pkg for the special codes, the keymap and the shift mapping.
//
// The input channel (in_valid, in_stall, in_scan_code) takes one raw set 1
// byte per transfer. The result channel (out_valid, out_stall,
// out_ascii_char) gives at most one character per byte, in byte order.
// Prefix bytes, the byte after a prefix, shift codes, other break codes and
// unmapped make codes give no result.
// A byte is first held in an input register; the keymap lookup, the shift
// mapping and the flag update then run combinationally into the result
// register, so a character passes the input register and then the result
// register before it shows on out_valid; a receiver stall can hold it between.
// Throughput is one byte per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its character and
// the input register holds the next byte; a further byte is refused with
// in_stall until the result is taken.
// A synchronous reset clears the valid bits of both registers and the shift and prefix flags.
module scancode_set1_to_ascii (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_scan_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_ascii_char
);

  logic                  s1_valid_r;
  sc1a_pkg::scan_code_t  s1_code_r;
  logic                  lshift_r;
  logic                  rshift_r;
  logic                  prefix_r;
  logic                  out_valid_r;
  sc1a_pkg::ascii_t      out_char_r;

  logic                  out_free;
  logic                  adv;
  logic                  in_take;
  logic                  lshift_nxt;
  logic                  rshift_nxt;
  logic                  prefix_nxt;
  logic                  hit;
  sc1a_pkg::ascii_t      base_char;
  sc1a_pkg::ascii_t      char_nxt;

  assign out_free = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign base_char = sc1a_pkg::keymap(s1_code_r[6:0]);

  always_comb begin
    lshift_nxt = lshift_r;
    rshift_nxt = rshift_r;
    prefix_nxt = prefix_r;
    hit        = 1'b0;
    char_nxt   = base_char;
    if (s1_code_r == sc1a_pkg::CODE_PREFIX) begin
      prefix_nxt = 1'b1;
    end else if (prefix_r) begin
      prefix_nxt = 1'b0;
    end else if (s1_code_r == sc1a_pkg::CODE_LSHIFT_MAKE) begin
      lshift_nxt = 1'b1;
    end else if (s1_code_r == sc1a_pkg::CODE_RSHIFT_MAKE) begin
      rshift_nxt = 1'b1;
    end else if (s1_code_r == sc1a_pkg::CODE_LSHIFT_BRK) begin
      lshift_nxt = 1'b0;
    end else if (s1_code_r == sc1a_pkg::CODE_RSHIFT_BRK) begin
      rshift_nxt = 1'b0;
    end else if (!s1_code_r[sc1a_pkg::BREAK_BIT] && base_char != '0) begin
      hit = 1'b1;
      if (lshift_r || rshift_r) begin
        char_nxt = sc1a_pkg::shifted(base_char);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      lshift_r    <= 1'b0;
      rshift_r    <= 1'b0;
      prefix_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        lshift_r <= lshift_nxt;
        rshift_r <= rshift_nxt;
        prefix_r <= prefix_nxt;
      end
      if (out_free) begin
        out_valid_r <= adv && hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_code_r <= in_scan_code;
    end
    if (out_free && adv && hit) begin
      out_char_r <= char_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ascii_char = out_char_r;

endmodule

FILE: sim/scancode_set1_to_ascii_tb.sv
// Self-checking testbench for the scan-code set 1 to ASCII decoder.
// Predicts every character from its own keymap and shift tracking and checks
// each transfer on the result channel in order; depends on sc1a_pkg and the RTL.
module scancode_set1_to_ascii_tb;

  class char_tracker;
    bit               lshift_down;
    bit               rshift_down;
    bit               after_prefix;
    sc1a_pkg::ascii_t pending_chars[$];
    int unsigned      mismatches;

    function new();
      lshift_down  = 1'b0;
      rshift_down  = 1'b0;
      after_prefix = 1'b0;
      mismatches   = 0;
    endfunction

    function logic [7:0] plain_char(input logic [6:0] code);
      logic [7:0] c;
      case (code)
        7'h02: c = "1";
        7'h03: c = "2";
        7'h04: c = "3";
        7'h05: c = "4";
        7'h06: c = "5";
        7'h07: c = "6";
        7'h08: c = "7";
        7'h09: c = "8";
        7'h0A: c = "9";
        7'h0B: c = "0";
        7'h0C: c = "-";
        7'h0D: c = "=";
        7'h0E: c = 8'h08;
        7'h10: c = "q";
        7'h11: c = "w";
        7'h12: c = "e";
        7'h13: c = "r";
        7'h14: c = "t";
        7'h15: c = "y";
        7'h16: c = "u";
        7'h17: c = "i";
        7'h18: c = "o";
        7'h19: c = "p";
        7'h1A: c = "[";
        7'h1B: c = "]";
        7'h1C: c = 8'h0A;
        7'h1E: c = "a";
        7'h1F: c = "s";
        7'h20: c = "d";
        7'h21: c = "f";
        7'h22: c = "g";
        7'h23: c = "h";
        7'h24: c = "j";
        7'h25: c = "k";
        7'h26: c = "l";
        7'h27: c = ";";
        7'h28: c = "'";
        7'h29: c = 8'h60;
        7'h2B: c = "\\";
        7'h2C: c = "z";
        7'h2D: c = "x";
        7'h2E: c = "c";
        7'h2F: c = "v";
        7'h30: c = "b";
        7'h31: c = "n";
        7'h32: c = "m";
        7'h33: c = ",";
        7'h34: c = ".";
        7'h35: c = "/";
        7'h39: c = " ";
        default: c = 8'h00;
      endcase
      return c;
    endfunction

    function logic [7:0] upper_char(input logic [7:0] c);
      logic [7:0] u;
      case (c)
        "1":   u = "!";
        "2":   u = "@";
        "3":   u = "#";
        "4":   u = "$";
        "5":   u = "%";
        "6":   u = "^";
        "7":   u = "&";
        "8":   u = "*";
        "9":   u = "(";
        "0":   u = ")";
        "-":   u = "_";
        "=":   u = "+";
        "[":   u = "{";
        "]":   u = "}";
        ";":   u = ":";
        "'":   u = "\"";
        8'h60: u = 8'h7E;
        "\\":  u = "|";
        ",":   u = "<";
        ".":   u = ">";
        "/":   u = "?";
        default: begin
          if (c >= "a" && c <= "z") begin
            u = c - 8'h20;
          end else begin
            u = c;
          end
        end
      endcase
      return u;
    endfunction

    function void note_code(input sc1a_pkg::scan_code_t code);
      logic [7:0] c;
      if (code == sc1a_pkg::CODE_PREFIX) begin
        after_prefix = 1'b1;
      end else if (after_prefix) begin
        after_prefix = 1'b0;
      end else if (code == sc1a_pkg::CODE_LSHIFT_MAKE) begin
        lshift_down = 1'b1;
      end else if (code == sc1a_pkg::CODE_RSHIFT_MAKE) begin
        rshift_down = 1'b1;
      end else if (code == sc1a_pkg::CODE_LSHIFT_BRK) begin
        lshift_down = 1'b0;
      end else if (code == sc1a_pkg::CODE_RSHIFT_BRK) begin
        rshift_down = 1'b0;
      end else if (!code[sc1a_pkg::BREAK_BIT]) begin
        c = plain_char(code[6:0]);
        if (c != 8'h00) begin
          if (lshift_down || rshift_down) begin
            c = upper_char(c);
          end
          pending_chars.push_back(c[6:0]);
        end
      end
    endfunction

    function void check_char(input sc1a_pkg::ascii_t actual);
      sc1a_pkg::ascii_t wanted;
      if (pending_chars.size() == 0) begin
        $error("out_ascii_char: expected no transfer, actual %h", actual);
        mismatches++;
      end else begin
        wanted = pending_chars.pop_front();
        if (actual !== wanted) begin
          $error("out_ascii_char: expected %h, actual %h", wanted, actual);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic [7:0] in_scan_code = 8'h00;
  logic       out_stall    = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [6:0] out_ascii_char;

  char_tracker tracker;
  int unsigned sender_idle_pct   = 6;
  int unsigned receiver_idle_pct = 84;
  int unsigned codes_sent        = 0;

  scancode_set1_to_ascii dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_scan_code   (in_scan_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ascii_char (out_ascii_char)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        tracker.check_char(out_ascii_char);
      end
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end
  end

  task automatic send_code(input sc1a_pkg::scan_code_t code);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_scan_code <= code;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    tracker.note_code(code);
    codes_sent++;
  endtask

  task automatic send_stroke();
    int unsigned          pick;
    sc1a_pkg::scan_code_t code;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      send_code(sc1a_pkg::scan_code_t'($urandom_range(1, 57)));
    end else if (pick < 67) begin
      case ($urandom_range(0, 3))
        0: send_code(sc1a_pkg::CODE_LSHIFT_MAKE);
        1: send_code(sc1a_pkg::CODE_RSHIFT_MAKE);
        2: send_code(sc1a_pkg::CODE_LSHIFT_BRK);
        default: send_code(sc1a_pkg::CODE_RSHIFT_BRK);
      endcase
    end else if (pick < 77) begin
      code = sc1a_pkg::scan_code_t'($urandom_range(1, 57));
      code[sc1a_pkg::BREAK_BIT] = 1'b1;
      send_code(code);
    end else if (pick < 85) begin
      send_code(sc1a_pkg::CODE_PREFIX);
      send_code(sc1a_pkg::scan_code_t'($urandom_range(0, 255)));
    end else begin
      send_code(sc1a_pkg::scan_code_t'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    #5_000_000;
    $display("scancode_set1_to_ascii_tb failed");
    $finish;
  end

  initial begin
    sc1a_pkg::scan_code_t directed[$];
    tracker = new();
    directed = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h1E, 8'h9E, 8'h02, 8'h0B,
                 sc1a_pkg::CODE_LSHIFT_MAKE, 8'h1E, 8'h02, 8'h29, 8'h39, 8'h1C,
                 8'h0E, sc1a_pkg::CODE_LSHIFT_BRK, sc1a_pkg::CODE_RSHIFT_MAKE,
                 8'h35, sc1a_pkg::CODE_PREFIX, sc1a_pkg::CODE_PREFIX,
                 sc1a_pkg::CODE_RSHIFT_BRK, 8'h2C, sc1a_pkg::CODE_RSHIFT_BRK,
                 sc1a_pkg::CODE_PREFIX, sc1a_pkg::CODE_LSHIFT_MAKE, 8'h2C};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_code(directed[i]);
    end
    while (codes_sent < 700) begin
      send_stroke();
    end
    sender_idle_pct   = 84;
    receiver_idle_pct = 6;
    while (codes_sent < 1400) begin
      send_stroke();
    end
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    while (codes_sent < 2025) begin
      send_stroke();
    end
    in_valid <= 1'b0;

    while (tracker.pending_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    if (tracker.pending_chars.size() != 0) begin
      $error("out_ascii_char: %0d expected characters never arrived",
             tracker.pending_chars.size());
      tracker.mismatches++;
    end
    if (tracker.mismatches == 0) begin
      $display("scancode_set1_to_ascii_tb passed");
    end else begin
      $display("scancode_set1_to_ascii_tb failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sc1a_pkg.sv
rtl/scancode_set1_to_ascii.sv
sim/scancode_set1_to_ascii_tb.sv
